/* src/smh_pkg.sv */
// Shared types and constants of the stereo channel mixer with high-pass filter.
// Used by smh_ctrl, smh_dp and the top level; depends on nothing else.
package smh_pkg;

  localparam int LEVEL_W    = 4;
  localparam int NUM_CH     = 4;
  localparam int IN_DATA_W  = NUM_CH * LEVEL_W;
  localparam int SAMPLE_W   = 16;
  localparam int OUT_DATA_W = 2 * SAMPLE_W;
  localparam int X_W        = 16;
  localparam int BIAS_W     = 48;
  localparam int DIFF_W     = 33;
  localparam int COEF_W     = 18;
  localparam int PROD_W     = DIFF_W + COEF_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic signed [COEF_W-1:0] HP_COEF = 18'sd57593;

  localparam logic [CFG_IDX_W-1:0] REG_MASTER_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROUTING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ROUTING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_VOLUME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_VOLUME  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_ACC_R,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_x;
    logic mul_en;
    logic mul_right;
    logic acc_l;
    logic acc_r;
    logic out_load;
  } dp_cmd_t;

endpackage

/* src/smh_ctrl.sv */
// Sequencer of the stereo mixer: steps the shared filter multiplier through both sides.
// Depends on smh_pkg; drives the command struct of smh_dp.
module smh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output smh_pkg::dp_cmd_t cmd
);
  import smh_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_x = 1'b1;
          state_nxt  = ST_MUL_L;
        end
      end
      ST_MUL_L: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_MUL_R;
      end
      ST_MUL_R: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_right = 1'b1;
        cmd.acc_l     = 1'b1;
        state_nxt     = ST_ACC_R;
      end
      ST_ACC_R: begin
        cmd.acc_r = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          in_tready    = 1'b1;
          if (in_tvalid) begin
            cmd.load_x = 1'b1;
            state_nxt  = ST_MUL_L;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

/* src/smh_dp.sv */
// Datapath of the stereo mixer: configuration registers, channel mix, shared filter
// multiplier, the two 48-bit biases and the output register. Depends on smh_pkg.
module smh_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [smh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smh_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [smh_pkg::IN_DATA_W-1:0]       in_tdata,
  input  smh_pkg::dp_cmd_t                    cmd,
  output logic [smh_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import smh_pkg::*;

  logic                     master_enable_r;
  logic [NUM_CH-1:0]        left_routing_r;
  logic [NUM_CH-1:0]        right_routing_r;
  logic [2:0]               left_volume_r;
  logic [2:0]               right_volume_r;

  logic                     en_r;
  logic signed [X_W-1:0]    xl_r, xr_r;
  logic signed [X_W-1:0]    xl_nxt, xr_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [BIAS_W-1:0] bias_l_r, bias_r_r;
  logic signed [BIAS_W-1:0] delta;
  logic signed [X_W-1:0]    sel_x;
  logic signed [BIAS_W-1:0] sel_b;
  logic signed [DIFF_W-1:0] diff;
  logic [SAMPLE_W-1:0]      yl, yr;
  logic [OUT_DATA_W-1:0]    out_data_r;

  function automatic logic signed [X_W-1:0] mix_side(
    input logic [IN_DATA_W-1:0] lv,
    input logic [NUM_CH-1:0]    rt,
    input logic [2:0]           vol
  );
    logic [5:0]         s;
    logic signed [15:0] m;
    logic signed [20:0] p;
    logic signed [20:0] q;
    s = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (rt[i]) begin
        s = s + {2'b00, lv[LEVEL_W*i +: LEVEL_W]};
      end
    end
    m = $signed({1'b0, s, 9'b0}) - 16'sd16384;
    p = m * $signed({2'b00, {1'b0, vol} + 4'd1});
    q = (p + (p[20] ? 21'sd7 : 21'sd0)) >>> 3;
    return q[X_W:1];
  endfunction

  function automatic logic [SAMPLE_W-1:0] hp_out(
    input logic signed [X_W-1:0]    x,
    input logic signed [BIAS_W-1:0] b
  );
    logic signed [SAMPLE_W:0] y;
    y = {x[X_W-1], x} - {b[BIAS_W-1], b[BIAS_W-1:BIAS_W-SAMPLE_W]};
    if (y[SAMPLE_W] != y[SAMPLE_W-1]) begin
      return y[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return y[SAMPLE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_enable_r <= 1'b0;
      left_routing_r  <= '0;
      right_routing_r <= '0;
      left_volume_r   <= '0;
      right_volume_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASTER_ENABLE: master_enable_r <= cfg_data[0];
        REG_LEFT_ROUTING:  left_routing_r  <= cfg_data[NUM_CH-1:0];
        REG_RIGHT_ROUTING: right_routing_r <= cfg_data[NUM_CH-1:0];
        REG_LEFT_VOLUME:   left_volume_r   <= cfg_data[2:0];
        REG_RIGHT_VOLUME:  right_volume_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign xl_nxt = mix_side(in_tdata, left_routing_r, left_volume_r);
  assign xr_nxt = mix_side(in_tdata, right_routing_r, right_volume_r);

  assign sel_x    = cmd.mul_right ? xr_r : xl_r;
  assign sel_b    = cmd.mul_right ? bias_r_r : bias_l_r;
  assign diff     = {sel_x[X_W-1], sel_x, 16'b0} - {sel_b[BIAS_W-1], sel_b[BIAS_W-1:16]};
  assign prod_nxt = diff * HP_COEF;
  assign delta    = {{(BIAS_W-(PROD_W-16)){prod_r[PROD_W-1]}}, prod_r[PROD_W-1:16]};

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      xl_r <= xl_nxt;
      xr_r <= xr_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b0;
      bias_l_r <= '0;
      bias_r_r <= '0;
    end else begin
      if (cmd.load_x) begin
        en_r <= master_enable_r;
      end
      if (cmd.acc_l) begin
        bias_l_r <= en_r ? bias_l_r + delta : '0;
      end
      if (cmd.acc_r) begin
        bias_r_r <= en_r ? bias_r_r + delta : '0;
      end
    end
  end

  assign yl = hp_out(xl_r, bias_l_r);
  assign yr = hp_out(xr_r, bias_r_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= en_r ? {yr, yl} : '0;
    end
  end

  assign out_tdata = out_data_r;

endmodule

/* src/stereo_channel_mixer_highpass_top.sv */
// Stereo channel mixer with DC-blocking high-pass: each input transaction carries four
// 4-bit channel levels and yields one transaction with the filtered left and right
// samples, or zeros if the master enable was off at acceptance. Each accepted item
// steps through ST_MUL_L, ST_MUL_R, ST_ACC_R and ST_FIN, where its result is loaded
// into the output register; a new item is taken only in ST_IDLE or in the cycle that
// result is loaded, so the block takes no new item before it is through with the last
// one. ST_MUL_L and ST_MUL_R run the one filter multiplier shared by both sides, the
// left bias update overlapping the right product; ST_ACC_R updates the right bias and
// ST_FIN saturates both samples into the output register. A result that waits on
// out_tready holds the next item at that last step. Configuration writes are always
// accepted and take effect for the next item. Depends on smh_pkg, smh_ctrl and smh_dp.
module stereo_channel_mixer_highpass_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] square_one_level, [7:4] square_two_level, [11:8] wave_level, [15:12] noise_level
  input  logic [smh_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] left_sample, [31:16] right_sample
  output logic [smh_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [smh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import smh_pkg::*;

  dp_cmd_t cmd;
  logic    cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  smh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  smh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .out_tdata (out_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while the filter sequence was still running");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result loaded over one that was not yet taken");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");

  a_single_bias_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.acc_l && cmd.acc_r))
    else $error("both biases updated from one product");

endmodule
